@@ rtl/core/ihtp_pkg.sv @@
// Shared constants and types for the indexed hex table text parser.
package ihtp_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned CharW  = 8;
  localparam int unsigned ErrW   = 2;
  localparam int unsigned ApbDW  = 32;
  localparam int unsigned ApbAW  = 3;

  localparam logic [DataW-1:0] MaxEntriesRst = 16'd1024;

  // register index in the configuration map
  localparam logic REG_MAX_ENTRIES = 1'b0;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 2'd0,
    ERR_ORDER     = 2'd1,
    ERR_LIMIT     = 2'd2,
    ERR_UNUSED    = 2'd3
  } err_t;

  localparam logic [CharW-1:0] ChHash    = 8'h23;
  localparam logic [CharW-1:0] ChSemi    = 8'h3B;
  localparam logic [CharW-1:0] ChZero    = 8'h30;
  localparam logic [CharW-1:0] ChNine    = 8'h39;
  localparam logic [CharW-1:0] ChNewline = 8'h0A;
  localparam logic [CharW-1:0] ChTab     = 8'h09;
  localparam logic [CharW-1:0] ChCr      = 8'h0D;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChLowA    = 8'h61;
  localparam logic [CharW-1:0] ChLowF    = 8'h66;
  localparam logic [CharW-1:0] ChUpA     = 8'h41;
  localparam logic [CharW-1:0] ChUpF     = 8'h46;

  typedef struct packed {
    logic             entry_valid;
    logic [DataW-1:0] entry_index;
    logic [DataW-1:0] entry_value;
    logic             finished;
    logic [DataW-1:0] entry_total;
    err_t             error_code;
  } res_t;

endpackage

@@ rtl/core/indexed_hex_table_text_parser_top.sv @@
// A result is registered in the output register, or in the skid if that one is held.
// Throughput: one character beat per cycle while in_stall is low; the parse step
// is a single mode update plus a by-10 or by-16 accumulate between the state and
// result registers. A two-deep result buffer (output register plus skid) lets input
// continue while out_stall holds a result; in_stall rises only when both are full.
// Reset (synchronous, rst_n low): parser between lines, counters zero, limit 1024.
module indexed_hex_table_text_parser_top
  import ihtp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CharW-1:0] in_char_code,
  input  logic             in_end_of_file,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_entry_valid,
  output logic [DataW-1:0] out_entry_index,
  output logic [DataW-1:0] out_entry_value,
  output logic             out_finished,
  output logic [DataW-1:0] out_entry_total,
  output logic [ErrW-1:0]  out_error_code,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAW-1:0] paddr,
  input  logic [ApbDW-1:0] pwdata,
  output logic [ApbDW-1:0] prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    M_BETWEEN,
    M_COMMENT,
    M_INDEX,
    M_BLANKS,
    M_HEX,
    M_SKIP,
    M_HALTED
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [DataW-1:0] idx_r, idx_nxt;
  logic [DataW-1:0] val_r, val_nxt;
  logic [DataW-1:0] cnt_r, cnt_nxt;
  logic [DataW-1:0] max_r;

  res_t             main_r, skid_r, res;
  logic             main_v_r, skid_v_r;
  logic             res_v;

  logic             in_acc, pop, cfg_wr;

  function automatic err_t check_index(input logic [DataW-1:0] idx,
                                       input logic [DataW-1:0] cnt,
                                       input logic [DataW-1:0] lim);
    err_t e;
    if (idx != cnt)       e = ERR_ORDER;
    else if (idx >= lim)  e = ERR_LIMIT;
    else                  e = ERR_NONE;
    return e;
  endfunction

  assign in_acc = in_valid && !in_stall;
  assign pop    = main_v_r && !out_stall;
  assign cfg_wr = psel && penable && pwrite && pready;

  // ---------------------------------------------------------------------------
  // Parse step
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [CharW-1:0] c;
    logic             is_space, is_blank, is_digit, is_hex;
    logic [3:0]       hval;
    logic [DataW-1:0] idx_w, val_w;
    logic             go_idx, go_blk, go_hex;
    err_t             err;

    c        = in_char_code;
    is_space = c inside {ChSpace, [ChTab:ChCr]};
    is_blank = c inside {ChSpace, ChTab};
    is_digit = c inside {[ChZero:ChNine]};
    is_hex   = 1'b1;
    hval     = '0;
    if (is_digit)                       hval = 4'(c - ChZero);
    else if (c inside {[ChLowA:ChLowF]}) hval = 4'(c - ChLowA + 8'd10);
    else if (c inside {[ChUpA:ChUpF]})   hval = 4'(c - ChUpA + 8'd10);
    else                                 is_hex = 1'b0;

    mode_nxt = mode_r;
    idx_nxt  = idx_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    idx_w    = idx_r;
    val_w    = val_r;
    go_idx   = 1'b0;
    go_blk   = 1'b0;
    go_hex   = 1'b0;
    err      = ERR_NONE;
    res_v    = 1'b0;
    res      = '0;

    if (mode_r == M_HALTED) begin
      // swallow everything until reset
    end else if (in_end_of_file) begin
      res_v    = 1'b1;
      mode_nxt = M_HALTED;
      if (mode_r == M_INDEX) begin
        err = check_index(idx_r, cnt_r, max_r);
        val_w = '0;
      end
      if (err != ERR_NONE) begin
        res.error_code = err;
      end else begin
        res.finished    = 1'b1;
        res.entry_total = cnt_r;
        if (mode_r inside {M_INDEX, M_BLANKS, M_HEX}) begin
          res.entry_valid = 1'b1;
          res.entry_index = idx_r;
          res.entry_value = val_w;
          res.entry_total = cnt_r + 1'b1;
          cnt_nxt         = cnt_r + 1'b1;
        end
      end
    end else begin
      case (mode_r)
        M_BETWEEN: begin
          if (c == ChHash || c == ChSemi) begin
            mode_nxt = M_COMMENT;
          end else if (!is_space) begin
            idx_w  = '0;
            go_idx = 1'b1;
          end
        end
        M_INDEX:  go_idx = 1'b1;
        M_BLANKS: go_blk = 1'b1;
        M_HEX:    go_hex = 1'b1;
        M_COMMENT, M_SKIP: begin
          if (c == ChNewline) mode_nxt = M_BETWEEN;
        end
        default: ;
      endcase

      if (go_idx) begin
        if (is_digit) begin
          idx_nxt  = (idx_w << 3) + (idx_w << 1) + DataW'(c - ChZero);
          mode_nxt = M_INDEX;
        end else begin
          err     = check_index(idx_w, cnt_r, max_r);
          idx_nxt = idx_w;
          if (err != ERR_NONE) begin
            res_v          = 1'b1;
            res.error_code = err;
            mode_nxt       = M_HALTED;
          end else begin
            val_w  = '0;
            go_blk = 1'b1;
          end
        end
      end

      if (go_blk) begin
        if (is_blank) begin
          val_nxt  = val_w;
          mode_nxt = M_BLANKS;
        end else begin
          go_hex = 1'b1;
        end
      end

      if (go_hex) begin
        if (is_hex) begin
          val_nxt  = {val_w[DataW-5:0], hval};
          mode_nxt = M_HEX;
        end else begin
          val_nxt         = val_w;
          res_v           = 1'b1;
          res.entry_valid = 1'b1;
          res.entry_index = idx_w;
          res.entry_value = val_w;
          cnt_nxt         = cnt_r + 1'b1;
          mode_nxt        = (c == ChNewline) ? M_BETWEEN : M_SKIP;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state and limit register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_BETWEEN;
      idx_r  <= '0;
      val_r  <= '0;
      cnt_r  <= '0;
      max_r  <= MaxEntriesRst;
    end else begin
      if (in_acc) begin
        mode_r <= mode_nxt;
        idx_r  <= idx_nxt;
        val_r  <= val_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (cfg_wr && paddr[ApbAW-1] == REG_MAX_ENTRIES) begin
        max_r <= pwdata[DataW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer: output register plus skid
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (in_acc && res_v) begin
      if (main_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) main_r <= skid_r;
    end else if (in_acc && res_v) begin
      if (main_v_r && !pop) skid_r <= res;
      else                  main_r <= res;
    end
  end

  assign in_stall        = skid_v_r;
  assign out_valid       = main_v_r;
  assign out_entry_valid = main_r.entry_valid;
  assign out_entry_index = main_r.entry_index;
  assign out_entry_value = main_r.entry_value;
  assign out_finished    = main_r.finished;
  assign out_entry_total = main_r.entry_total;
  assign out_error_code  = main_r.error_code;

  assign pready = 1'b1;
  assign prdata = (paddr[ApbAW-1] == REG_MAX_ENTRIES) ? ApbDW'(max_r) : '0;

endmodule

@@ rtl/core/ihtp_checker.sv @@
// Port-level checker for the parser top level, bound in below.
module ihtp_checker
  import ihtp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_entry_valid,
  input logic [DataW-1:0] out_entry_index,
  input logic [DataW-1:0] out_entry_value,
  input logic             out_finished,
  input logic [DataW-1:0] out_entry_total,
  input logic [ErrW-1:0]  out_error_code
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_index)
      && $stable(out_entry_value) && $stable(out_entry_total)
      && $stable(out_error_code))
    else $error("result beat changed while stalled");

  // an error beat carries nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> !out_entry_valid && !out_finished
      && out_entry_total == '0)
    else $error("error beat carries payload");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code != ERR_UNUSED)
    else $error("undefined error code");

  // every beat is an entry, an end of file or an error
  a_beat_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_valid || out_finished || out_error_code != ERR_NONE)
    else $error("empty result beat");

  a_total_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_finished |-> out_entry_total == '0)
    else $error("entry total set without finished");

endmodule

bind indexed_hex_table_text_parser_top ihtp_checker u_ihtp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_entry_valid (out_entry_valid),
  .out_entry_index (out_entry_index),
  .out_entry_value (out_entry_value),
  .out_finished    (out_finished),
  .out_entry_total (out_entry_total),
  .out_error_code  (out_error_code)
);

@@ tb/tb.sv @@
// Self-checking testbench for the indexed hex table text parser.
module tb
  import ihtp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PM_BETWEEN, PM_COMMENT, PM_INDEX, PM_BLANKS, PM_HEX, PM_SKIP, PM_HALTED
  } parse_mode_t;

  typedef enum logic [1:0] {ST_NONE, ST_LIGHT, ST_HEAVY, ST_BURSTY} stall_style_t;

  localparam logic [ApbAW-1:0] LimitAddr = ApbAW'(4 * REG_MAX_ENTRIES);

  // Tracks the parser's table state and holds the results still owed by the block.
  class table_parse_board;
    parse_mode_t pmode;
    logic [DataW-1:0] idx_acc, val_acc, n_entries, limit;
    res_t pending_entries[$];
    int errors;

    function new();
      pmode     = PM_BETWEEN;
      idx_acc   = '0;
      val_acc   = '0;
      n_entries = '0;
      limit     = MaxEntriesRst;
      errors    = 0;
    endfunction

    static function int hex_of(logic [CharW-1:0] c);
      if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
      if (c >= ChLowA && c <= ChLowF) return int'(c - ChLowA) + 10;
      if (c >= ChUpA && c <= ChUpF) return int'(c - ChUpA) + 10;
      return -1;
    endfunction

    function err_t index_verdict();
      if (idx_acc != n_entries) return ERR_ORDER;
      if (idx_acc >= limit) return ERR_LIMIT;
      return ERR_NONE;
    endfunction

    function void add_entry(inout res_t r);
      r.entry_valid = 1'b1;
      r.entry_index = idx_acc;
      r.entry_value = val_acc;
      n_entries     = n_entries + 1'b1;
    endfunction

    function void take_char(logic [CharW-1:0] c, logic eof);
      res_t r;
      err_t e;
      int h;
      r = res_t'(0);
      if (pmode == PM_HALTED) return;
      if (eof) begin
        if (pmode == PM_INDEX || pmode == PM_BLANKS || pmode == PM_HEX) begin
          if (pmode == PM_INDEX) begin
            e = index_verdict();
            if (e != ERR_NONE) begin
              r.error_code = e;
              pmode = PM_HALTED;
              pending_entries.push_back(r);
              return;
            end
            val_acc = '0;
          end
          add_entry(r);
        end
        r.finished    = 1'b1;
        r.entry_total = n_entries;
        pmode = PM_HALTED;
        pending_entries.push_back(r);
        return;
      end
      if (pmode == PM_COMMENT || pmode == PM_SKIP) begin
        if (c == ChNewline) pmode = PM_BETWEEN;
        return;
      end
      if (pmode == PM_BETWEEN) begin
        if (c == ChSpace || (c >= ChTab && c <= ChCr)) return;
        if (c == ChHash || c == ChSemi) begin
          pmode = PM_COMMENT;
          return;
        end
        idx_acc = '0;
        pmode = PM_INDEX;
      end
      if (pmode == PM_INDEX) begin
        if (c >= ChZero && c <= ChNine) begin
          idx_acc = DataW'(idx_acc * 10 + (c - ChZero));
          return;
        end
        e = index_verdict();
        if (e != ERR_NONE) begin
          r.error_code = e;
          pmode = PM_HALTED;
          pending_entries.push_back(r);
          return;
        end
        val_acc = '0;
        pmode = PM_BLANKS;
      end
      if (pmode == PM_BLANKS) begin
        if (c == ChSpace || c == ChTab) return;
        pmode = PM_HEX;
      end
      h = hex_of(c);
      if (h >= 0) begin
        val_acc = {val_acc[DataW-5:0], 4'(h)};
        return;
      end
      add_entry(r);
      pending_entries.push_back(r);
      pmode = (c == ChNewline) ? PM_BETWEEN : PM_SKIP;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] beat mismatch: %s", $time, msg);
    endtask

    task field(string name, logic [DataW-1:0] seen, logic [DataW-1:0] want);
      if (seen !== want) report($sformatf("%s got %0h, expected %0h", name, seen, want));
    endtask

    task match_result(res_t seen);
      res_t want;
      if (pending_entries.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      want = pending_entries.pop_front();
      field("entry_valid", seen.entry_valid, want.entry_valid);
      field("entry_index", seen.entry_index, want.entry_index);
      field("entry_value", seen.entry_value, want.entry_value);
      field("finished", seen.finished, want.finished);
      field("entry_total", seen.entry_total, want.entry_total);
      field("error_code", seen.error_code, want.error_code);
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [CharW-1:0] in_char_code;
  logic             in_end_of_file;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_entry_valid;
  logic [DataW-1:0] out_entry_index;
  logic [DataW-1:0] out_entry_value;
  logic             out_finished;
  logic [DataW-1:0] out_entry_total;
  logic [ErrW-1:0]  out_error_code;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [ApbAW-1:0] paddr;
  logic [ApbDW-1:0] pwdata;
  logic [ApbDW-1:0] prdata;
  logic             pready;

  table_parse_board sb;
  int unsigned next_idx = 0;
  int sent_count = 0;
  int burst_left = 0;
  int unsigned hold_left = 0;
  stall_style_t stall_style = ST_NONE;

  indexed_hex_table_text_parser_top u_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_char_code, .in_end_of_file,
    .out_valid, .out_stall,
    .out_entry_valid, .out_entry_index, .out_entry_value,
    .out_finished, .out_entry_total, .out_error_code,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // result side: check accepted beats, stall in changing styles
  always @(posedge clk) begin : result_side
    res_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.entry_valid = out_entry_valid;
      seen.entry_index = out_entry_index;
      seen.entry_value = out_entry_value;
      seen.finished    = out_finished;
      seen.entry_total = out_entry_total;
      seen.error_code  = err_t'(out_error_code);
      sb.match_result(seen);
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0) begin
        stall_style <= stall_style_t'($urandom_range(0, 3));
        hold_left   <= $urandom_range(16, 160);
      end else begin
        hold_left <= hold_left - 1;
      end
      case (stall_style)
        ST_NONE:  out_stall <= 1'b0;
        ST_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        ST_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= (hold_left[3:0] < 4'd5);
      endcase
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("indexed_hex_table_text_parser_top regression: fail");
    $finish;
  end

  function automatic logic [CharW-1:0] pick_space();
    int v;
    v = $urandom_range(0, 5);
    return (v == 5) ? ChSpace : CharW'(ChTab + v);
  endfunction

  function automatic logic [CharW-1:0] pick_hex();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  // anything that closes a value without being a newline
  function automatic logic [CharW-1:0] pick_ender();
    logic [CharW-1:0] c;
    do c = CharW'($urandom_range(0, 255));
    while (table_parse_board::hex_of(c) >= 0 || c == ChNewline);
    return c;
  endfunction

  function automatic logic [CharW-1:0] pick_junk();
    logic [CharW-1:0] c;
    do c = CharW'($urandom_range(0, 255));
    while (c == ChNewline);
    return c;
  endfunction

  task automatic send_beat(logic [CharW-1:0] c, logic eof);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_char_code   <= c;
    in_end_of_file <= eof;
    do @(posedge clk); while (in_stall);
    sb.take_char(c, eof);
    sent_count++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // drain every owed result, then give the block time to finish silent work
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_entries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [DataW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LimitAddr;
    pwdata  <= {DataW'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.limit = v;
  endtask

  task automatic send_comment();
    send_beat(($urandom_range(0, 1) != 0) ? ChHash : ChSemi, 1'b0);
    repeat ($urandom_range(0, 12)) send_beat(pick_junk(), 1'b0);
    send_beat(ChNewline, 1'b0);
  endtask

  task automatic send_entry(int unsigned idx_num);
    logic [CharW-1:0] hexq[$];
    int n_hex;
    bit tight;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_beat(pick_space(), 1'b0);
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) send_beat(ChZero, 1'b0);
    send_text($sformatf("%0d", idx_num));
    n_hex = $urandom_range(0, 6);
    repeat (n_hex) hexq.push_back(pick_hex());
    // value may butt against the index only when it opens with a letter
    tight = (n_hex == 0 || table_parse_board::hex_of(hexq[0]) >= 10)
            && $urandom_range(0, 2) == 0;
    if (!tight) repeat ($urandom_range(1, 3))
      send_beat(($urandom_range(0, 1) != 0) ? ChSpace : ChTab, 1'b0);
    foreach (hexq[k]) send_beat(hexq[k], 1'b0);
    // trailing text opens with a non-hex byte so it never runs into the value
    if ($urandom_range(0, 9) >= 3) begin
      send_beat(pick_ender(), 1'b0);
      repeat ($urandom_range(0, 7)) send_beat(pick_junk(), 1'b0);
    end
    send_beat(ChNewline, 1'b0);
    next_idx++;
  endtask

  task automatic run_phase(int n_chars, bit entries_ok);
    int start;
    int pick;
    start = sent_count;
    while (sent_count - start < n_chars) begin
      pick = $urandom_range(0, 99);
      if (entries_ok && pick < 75) begin
        // occasionally spell the index with a wrapped-around value
        send_entry(next_idx + (($urandom_range(0, 7) == 0) ? 65536 * $urandom_range(1, 3) : 0));
      end else if (pick % 2 != 0) begin
        send_comment();
      end else begin
        repeat ($urandom_range(1, 4)) send_beat(pick_space(), 1'b0);
      end
    end
  endtask

  // the one stream-ending event of the run, chosen by the seed
  task automatic finish_stream();
    int kind;
    int sub;
    kind = $urandom_range(0, 4);
    sub  = $urandom_range(0, 2);
    case (kind)
      0: begin
        if (sub == 1) begin
          send_beat(ChHash, 1'b0);
          repeat ($urandom_range(0, 5)) send_beat(pick_junk(), 1'b0);
        end else if (sub == 2) begin
          send_text($sformatf("%0d a,", next_idx));
          next_idx++;
        end
      end
      1: begin
        send_text($sformatf("%0d", next_idx));
        if (sub != 0) send_beat(ChSpace, 1'b0);
        if (sub == 2) repeat ($urandom_range(1, 5)) send_beat(pick_hex(), 1'b0);
      end
      2: send_text($sformatf("%0d", next_idx + $urandom_range(1, 5)));
      default: begin
        settle();
        write_limit(DataW'($urandom_range(0, next_idx)));
        send_text($sformatf("%0d", (kind == 3) ? next_idx : next_idx + $urandom_range(1, 5)));
      end
    endcase
    if (kind >= 2 && $urandom_range(0, 1) != 0) send_beat(ChNewline, 1'b0);
    send_beat(CharW'($urandom), 1'b1);
    // halted from here on: nothing may come out
    repeat ($urandom_range(3, 8)) send_beat(CharW'($urandom), 1'($urandom));
  endtask

  initial begin : stimulus
    sb = new();
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_char_code   <= '0;
    in_end_of_file <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed text under the reset limit
    send_text("fF\n");        // line opens with a hex letter: index 0, value ff
    send_beat(ChSemi, 1'b0);  // comment holding a top-bit byte
    send_beat(8'hFF, 1'b0);
    send_beat(ChNewline, 1'b0);
    send_text("1 1ffff\n");   // value wraps to ffff
    send_text("2Ab;z\n");     // value straight after the index, junk after it
    send_text("65539\n");     // index wraps to 3, no value
    next_idx = 4;

    settle();
    write_limit(16'hFFFF);
    run_phase(300, 1'b1);

    // zero limit: only text that never reaches an index check
    settle();
    write_limit('0);
    run_phase(40, 1'b0);

    // last index below the limit is still accepted
    settle();
    write_limit(DataW'(next_idx + 1));
    send_entry(next_idx);

    for (int p = 0; p < 4; p++) begin
      settle();
      write_limit(DataW'($urandom_range(next_idx + 400, 65535)));
      run_phase(270, 1'b1);
    end

    finish_stream();

    in_valid <= 1'b0;
    while (sb.pending_entries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending_entries.size() != 0) sb.report("results still outstanding at end");
    if (sb.errors == 0) begin
      $display("indexed_hex_table_text_parser_top regression: pass");
    end else begin
      $display("indexed_hex_table_text_parser_top regression: fail");
    end
    $finish;
  end

endmodule
